// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker of the dispatch unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ECD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecd: same-cycle property violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ECD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecd: next-cycle property violated");

`endif

// ----- hw/rtl/ecd_pkg.sv -----
// Types, codes and helper functions of the elevator call table dispatch unit.
package ecd_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } opcode_t;

    localparam logic [1:0] BTN_HALL_UP   = 2'd0;
    localparam logic [1:0] BTN_HALL_DOWN = 2'd1;
    localparam logic [1:0] BTN_CAB       = 2'd2;
    localparam logic [1:0] BTN_UNUSED    = 2'd3;

    localparam logic [1:0] DIR_DOWN = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd2;

    typedef enum logic [2:0] {
        ORD_NONE = 3'd0,
        ORD_UP   = 3'd1,
        ORD_DOWN = 3'd2,
        ORD_BOTH = 3'd3,
        ORD_CAB  = 3'd4
    } order_t;

    typedef enum logic [2:0] {
        CMD_NOP    = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_QUERY  = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [1:0] floor;
        logic [1:0] button;
        logic       up_ok;
        logic       down_ok;
        logic [1:0] last_floor;
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    function automatic order_t merge_order(order_t cur, logic [1:0] button);
        order_t res;
        res = cur;
        if (cur != ORD_CAB)
        begin
            case (button)
                BTN_HALL_UP:   res = (cur == ORD_NONE || cur == ORD_UP) ? ORD_UP : ORD_BOTH;
                BTN_HALL_DOWN: res = (cur == ORD_NONE || cur == ORD_DOWN) ? ORD_DOWN : ORD_BOTH;
                BTN_CAB:       res = ORD_CAB;
                default:       res = cur;
            endcase
        end
        return res;
    endfunction

    function automatic logic is_eligible(order_t code, logic up_ok, logic down_ok);
        logic ok;
        ok = (code != ORD_NONE);
        if (code == ORD_UP && !up_ok)
        begin
            ok = 1'b0;
        end
        if (code == ORD_DOWN && !down_ok)
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ----- hw/rtl/ecd_front.sv -----
// Input handshake and command decode of the elevator call table dispatch unit.
module ecd_front #(
    parameter int FLOORS = 4
) (
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    opcode,
    input  logic [1:0]    floor,
    input  logic [1:0]    button,
    input  logic [1:0]    direction,
    input  logic [1:0]    last_floor,
    input  logic          q_full,
    output logic          q_push,
    output ecd_pkg::cmd_t q_cmd
);
    import ecd_pkg::*;

    logic floor_ok;
    logic button_ok;

    always_comb
    begin
        floor_ok  = (int'(floor) < FLOORS);
        button_ok = (button != BTN_UNUSED);

        q_cmd.floor      = floor;
        q_cmd.button     = button;
        q_cmd.up_ok      = (direction != DIR_DOWN);
        q_cmd.down_ok    = (direction != DIR_UP);
        q_cmd.last_floor = last_floor;

        unique case (opcode)
            OP_ADD:    q_cmd.kind = (floor_ok && button_ok) ? CMD_ADD : CMD_NOP;
            OP_REMOVE: q_cmd.kind = floor_ok ? CMD_REMOVE : CMD_NOP;
            OP_CLEAR:  q_cmd.kind = CMD_CLEAR;
            OP_QUERY:  q_cmd.kind = CMD_QUERY;
            default:   q_cmd.kind = CMD_NOP;
        endcase
    end

    // A transaction that changes nothing is accepted and dropped.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && (q_cmd.kind != CMD_NOP);

endmodule

// ----- hw/rtl/ecd_cmd_queue.sv -----
// Short command queue between the decode front and the table back end.
module ecd_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ecd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output ecd_pkg::cmd_t head
);
    import ecd_pkg::*;

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    assign full  = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/ecd_back.sv -----
// Order table, nearest-call scan and result register of the dispatch unit.
module ecd_back #(
    parameter int FLOORS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ecd_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          found,
    output logic [1:0]    destination
);
    import ecd_pkg::*;

    localparam int IDX_W  = (FLOORS > 2) ? $clog2(FLOORS) : 1;
    localparam int DIST_W = (IDX_W > 2) ? IDX_W : 2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } back_state_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    order_t            table_reg [FLOORS];
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              up_ok_reg;
    logic              up_ok_next;
    logic              down_ok_reg;
    logic              down_ok_next;
    logic [1:0]        last_reg;
    logic [1:0]        last_next;
    logic              hit_reg;
    logic              hit_next;
    logic [IDX_W-1:0]  best_reg;
    logic [IDX_W-1:0]  best_next;
    logic [DIST_W-1:0] best_dist_reg;
    logic [DIST_W-1:0] best_dist_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              found_reg;
    logic              found_next;
    logic [1:0]        destination_reg;
    logic [1:0]        destination_next;

    logic [DIST_W-1:0] floor_ext;
    logic [IDX_W-1:0]  cmd_addr;
    logic [IDX_W-1:0]  rd_addr;
    order_t            rd_code;
    logic [DIST_W-1:0] idx_ext;
    logic [DIST_W-1:0] last_ext;
    logic [DIST_W-1:0] cur_dist;
    logic              take;
    logic              scan_last;
    logic              out_free;
    logic              advance;
    logic [IDX_W-1:0]  pick;
    logic [DIST_W-1:0] pick_ext;
    logic              wr_en;
    order_t            wr_data;
    logic              clr_all;

    always_comb
    begin
        floor_ext = DIST_W'(q_head.floor);
        cmd_addr  = floor_ext[IDX_W-1:0];
        rd_addr   = (state_reg == ST_SCAN) ? idx_reg : cmd_addr;
        rd_code   = table_reg[rd_addr];

        idx_ext  = DIST_W'(idx_reg);
        last_ext = DIST_W'(last_reg);
        cur_dist = (idx_ext >= last_ext) ? idx_ext - last_ext : last_ext - idx_ext;

        // Strictly nearer only, so the lower floor keeps a tie.
        take      = is_eligible(rd_code, up_ok_reg, down_ok_reg)
                    && (!hit_reg || cur_dist < best_dist_reg);
        scan_last = (idx_reg == IDX_W'(FLOORS - 1));
        out_free  = !out_valid_reg || !out_stall;
        advance   = !scan_last || out_free;
        pick      = take ? idx_reg : best_reg;
        pick_ext  = DIST_W'(pick);
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        up_ok_next       = up_ok_reg;
        down_ok_next     = down_ok_reg;
        last_next        = last_reg;
        hit_next         = hit_reg;
        best_next        = best_reg;
        best_dist_next   = best_dist_reg;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        destination_next = destination_reg;
        q_pop            = 1'b0;
        wr_en            = 1'b0;
        wr_data          = ORD_NONE;
        clr_all          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.kind)
                        CMD_ADD:
                        begin
                            wr_en   = 1'b1;
                            wr_data = merge_order(rd_code, q_head.button);
                        end
                        CMD_REMOVE:
                        begin
                            wr_en   = 1'b1;
                            wr_data = ORD_NONE;
                        end
                        CMD_CLEAR:
                        begin
                            clr_all = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            state_next     = ST_SCAN;
                            idx_next       = '0;
                            up_ok_next     = q_head.up_ok;
                            down_ok_next   = q_head.down_ok;
                            last_next      = q_head.last_floor;
                            hit_next       = 1'b0;
                            best_next      = '0;
                            best_dist_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (take)
                    begin
                        hit_next       = 1'b1;
                        best_next      = idx_reg;
                        best_dist_next = cur_dist;
                    end
                    if (scan_last)
                    begin
                        out_valid_next   = 1'b1;
                        found_next       = hit_reg || take;
                        destination_next = (hit_reg || take) ? pick_ext[1:0] : 2'd0;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FLOORS; i++)
            begin
                table_reg[i] <= ORD_NONE;
            end
        end
        else if (clr_all)
        begin
            for (int i = 0; i < FLOORS; i++)
            begin
                table_reg[i] <= ORD_NONE;
            end
        end
        else if (wr_en)
        begin
            table_reg[cmd_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        up_ok_reg       <= up_ok_next;
        down_ok_reg     <= down_ok_next;
        last_reg        <= last_next;
        hit_reg         <= hit_next;
        best_reg        <= best_next;
        best_dist_reg   <= best_dist_next;
        found_reg       <= found_next;
        destination_reg <= destination_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign destination = destination_reg;

endmodule

// ----- hw/rtl/elevator_call_table_dispatch_unit.sv -----
// Top level of the elevator call table dispatch unit.
// The unit keeps one order code per floor and answers queries with the nearest eligible
// floor. The front decodes each input transaction and parks it in a two-entry command
// queue, so new transactions are taken while the back end is busy or a result waits,
// until the queue is full. The back end runs add, remove and clear straight from idle.
// A query starts a scan in which the single table read port walks the floors in order;
// the scan holds on the last floor while an earlier result is stalled. The result then
// sits in the output register until taken. Only queries produce an output transaction.
module elevator_call_table_dispatch_unit #(
    parameter int FLOORS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [1:0] floor,
    input  logic [1:0] button,
    input  logic [1:0] direction,
    input  logic [1:0] last_floor,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       found,
    output logic [1:0] destination
);
    import ecd_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic q_empty;
    cmd_t q_head;

    ecd_front #(
        .FLOORS(FLOORS)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .floor     (floor),
        .button    (button),
        .direction (direction),
        .last_floor(last_floor),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    ecd_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(q_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    ecd_back #(
        .FLOORS(FLOORS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .destination(destination)
    );

endmodule

// ----- hw/rtl/ecd_checker.sv -----
// Port-level checker of the elevator call table dispatch unit and its bind.
`include "assert_macros.svh"

module ecd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       found,
    input logic [1:0] destination
);

    // A miss always reports floor zero.
    `ECD_ASSERT_IMPL(a_miss_dest_zero, clk, rst_n, out_valid && !found, destination == 2'd0)

    // A stalled result stays and keeps its payload.
    `ECD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(destination))

    // Right after reset the input is not stalled and no result is pending.
    `ECD_ASSERT_IMPL(a_reset_state, clk, rst_n, !$past(rst_n), !in_stall && !out_valid)

endmodule

bind elevator_call_table_dispatch_unit ecd_checker u_ecd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .destination(destination)
);
